@@ rtl/gfpd_pkg.sv @@
// Package: shared types, constants and the exp table builder for the falloff pipeline.
`default_nettype none
package gfpd_pkg;

	// Default interpolation table size, as log2 of the number of intervals
	localparam int EXP_TABLE_BITS_DEF = 8;

	// Configuration register indices
	typedef enum logic [2:0] {
		REG_NORMAL_X = 3'd0,
		REG_NORMAL_Y = 3'd1,
		REG_NORMAL_Z = 3'd2,
		REG_PICK_X   = 3'd3,
		REG_PICK_Y   = 3'd4,
		REG_PICK_Z   = 3'd5,
		REG_PUSH     = 3'd6,
		REG_SIGMA    = 3'd7
	} reg_idx_t;

	// Register reset values
	localparam logic [15:0] NORMAL_Z_RST = 16'd16384;
	localparam logic [15:0] SIGMA_RST    = 16'd7680;

	// One vertex, Q16.16
	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	// Configuration register file
	typedef struct packed {
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic signed [31:0] pick_x;
		logic signed [31:0] pick_y;
		logic signed [31:0] pick_z;
		logic signed [31:0] push_amount;
		logic        [15:0] sigma;
	} cfg_t;

	// Shift-and-subtract division, for elaboration-time table building only
	function automatic logic [63:0] udiv64(logic [63:0] n, logic [63:0] d);
		logic [63:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[62:0], n[i]};
			if (r >= d) begin
				r = r - d;
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Table entry k: exp(-k*h) in Q1.16, h = 2^(4-bits), from a Taylor series base
	function automatic logic [16:0] exp_entry(int bits, int k);
		logic [63:0]        term;
		logic signed [63:0] base;
		logic [63:0]        e;
		term = 64'd1 << 30;
		base = 64'sd1 <<< 30;
		for (int j = 1; j <= 20; j++) begin
			term = udiv64(term >> (bits - 4), 64'(j));
			if (j % 2 == 1) begin
				base = base - $signed(term);
			end else begin
				base = base + $signed(term);
			end
		end
		if (base < 0) begin
			base = '0;
		end
		e = 64'd1 << 30;
		for (int j = 0; j < k; j++) begin
			e = (e * 64'(base) + (64'd1 << 29)) >> 30;
		end
		return 17'((e + 64'd8192) >> 14);
	endfunction

endpackage
`default_nettype wire

@@ rtl/gfpd_cross.sv @@
// Cross product of the normal with the pick offset, rounded magnitudes and squared distance.
`default_nettype none
module gfpd_cross (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire gfpd_pkg::cfg_t   cfg,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire gfpd_pkg::point_t in_pt,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output gfpd_pkg::point_t      out_pt,
	output logic [57:0]           out_d2,
	output logic                  out_far
);

	localparam int NS = 5;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] vin;
	logic [NS:0]   adv;
	logic [NS-1:0] ld;

	// Stall chain: a stage loads when empty or when the next one moves
	assign adv[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end
	assign vin      = {vld_q[NS-2:0], in_valid};
	assign ld       = adv[NS-1:0] & vin;
	assign in_ready = adv[0];
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (adv[k]) vld_q[k] <= vin[k];
			end
		end
	end

	// Magnitude rounded from Q.30 to Q.16
	function automatic logic [35:0] abs_round14(logic signed [49:0] v);
		logic [49:0] m;
		m = v[49] ? 50'(-v) : 50'(v);
		return 36'((m + 50'd8192) >> 14);
	endfunction

	gfpd_pkg::point_t   pt_s1, pt_s2, pt_s3, pt_s4, pt_s5;
	logic signed [32:0] dx_s1, dy_s1, dz_s1;
	logic signed [48:0] p_yz_s2, p_zy_s2, p_zx_s2, p_xz_s2, p_xy_s2, p_yx_s2;
	logic [35:0]        cx_s3, cy_s3, cz_s3;
	logic [55:0]        sx_s4, sy_s4, sz_s4;
	logic               far_s4, far_s5;
	logic [57:0]        d2_s5;

	// Offset from vertex to picked point
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			pt_s1 <= in_pt;
			dx_s1 <= {cfg.pick_x[31], cfg.pick_x} - {in_pt.x[31], in_pt.x};
			dy_s1 <= {cfg.pick_y[31], cfg.pick_y} - {in_pt.y[31], in_pt.y};
			dz_s1 <= {cfg.pick_z[31], cfg.pick_z} - {in_pt.z[31], in_pt.z};
		end
	end

	// Cross product partial products
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			pt_s2   <= pt_s1;
			p_yz_s2 <= 49'($signed(cfg.normal_y)) * 49'(dz_s1);
			p_zy_s2 <= 49'($signed(cfg.normal_z)) * 49'(dy_s1);
			p_zx_s2 <= 49'($signed(cfg.normal_z)) * 49'(dx_s1);
			p_xz_s2 <= 49'($signed(cfg.normal_x)) * 49'(dz_s1);
			p_xy_s2 <= 49'($signed(cfg.normal_x)) * 49'(dy_s1);
			p_yx_s2 <= 49'($signed(cfg.normal_y)) * 49'(dx_s1);
		end
	end

	// Cross components, rounded magnitudes
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			pt_s3 <= pt_s2;
			cx_s3 <= abs_round14(50'(p_yz_s2) - 50'(p_zy_s2));
			cy_s3 <= abs_round14(50'(p_zx_s2) - 50'(p_xz_s2));
			cz_s3 <= abs_round14(50'(p_xy_s2) - 50'(p_yx_s2));
		end
	end

	// Squares, and flag a component of 4096.0 or more
	always_ff @(posedge clk) begin
		if (ld[3]) begin
			pt_s4  <= pt_s3;
			far_s4 <= (|cx_s3[35:28]) || (|cy_s3[35:28]) || (|cz_s3[35:28]);
			sx_s4  <= 56'(cx_s3[27:0]) * 56'(cx_s3[27:0]);
			sy_s4  <= 56'(cy_s3[27:0]) * 56'(cy_s3[27:0]);
			sz_s4  <= 56'(cz_s3[27:0]) * 56'(cz_s3[27:0]);
		end
	end

	// Squared distance
	always_ff @(posedge clk) begin
		if (ld[4]) begin
			pt_s5  <= pt_s4;
			far_s5 <= far_s4;
			d2_s5  <= 58'(sx_s4) + 58'(sy_s4) + 58'(sz_s4);
		end
	end

	assign out_pt  = pt_s5;
	assign out_d2  = d2_s5;
	assign out_far = far_s5;

endmodule
`default_nettype wire

@@ rtl/gfpd_div.sv @@
// Pipelined restoring divider: exp argument d2 / (2 sigma^2), one quotient bit per stage.
`default_nettype none
module gfpd_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [32:0]      den,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire gfpd_pkg::point_t in_pt,
	input  wire logic [57:0]      in_d2,
	input  wire logic             in_far,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output gfpd_pkg::point_t      out_pt,
	output logic [19:0]           out_x,
	output logic                  out_zero
);

	localparam int QB = 20;
	localparam int NS = QB + 1;
	localparam int RW = 53;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] vin;
	logic [NS:0]   adv;
	logic [NS-1:0] ld;

	// Stall chain: a stage loads when empty or when the next one moves
	assign adv[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end
	assign vin       = {vld_q[NS-2:0], in_valid};
	assign ld        = adv[NS-1:0] & vin;
	assign in_ready  = adv[0];
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (adv[k]) vld_q[k] <= vin[k];
			end
		end
	end

	gfpd_pkg::point_t pt_s   [NS];
	logic [RW-1:0]    rem_s  [NS];
	logic [QB-1:0]    quo_s  [NS];
	logic             zero_s [NS];

	// Range check: quotient of 16.0 or more, a far vertex or zero sigma gives weight 0
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			pt_s[0]   <= in_pt;
			zero_s[0] <= in_far || (den == '0) || (in_d2 >= {5'd0, den, 20'd0});
			rem_s[0]  <= in_d2[RW-1:0];
			quo_s[0]  <= '0;
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar k = 1; k < NS; k++) begin : g_bit
		logic [RW-1:0] sub;
		logic          take;
		assign sub  = RW'(den) << (QB - k);
		assign take = rem_s[k-1] >= sub;
		always_ff @(posedge clk) begin
			if (ld[k]) begin
				pt_s[k]   <= pt_s[k-1];
				zero_s[k] <= zero_s[k-1];
				rem_s[k]  <= take ? (rem_s[k-1] - sub) : rem_s[k-1];
				quo_s[k]  <= {quo_s[k-1][QB-2:0], take};
			end
		end
	end

	assign out_pt   = pt_s[NS-1];
	assign out_x    = quo_s[NS-1];
	assign out_zero = zero_s[NS-1];

endmodule
`default_nettype wire

@@ rtl/gfpd_exp.sv @@
// Table lookup and linear interpolation of exp(-x) for x in [0,16).
`default_nettype none
module gfpd_exp #(
	parameter int EXP_TABLE_BITS = gfpd_pkg::EXP_TABLE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire gfpd_pkg::point_t in_pt,
	input  wire logic [19:0]      in_x,
	input  wire logic             in_zero,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output gfpd_pkg::point_t      out_pt,
	output logic [16:0]           out_wi
);

	localparam int NS   = 3;
	localparam int FB   = 20 - EXP_TABLE_BITS;
	localparam int TLEN = (1 << EXP_TABLE_BITS) + 1;
	localparam int PW   = 17 + FB;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] vin;
	logic [NS:0]   adv;
	logic [NS-1:0] ld;

	// Stall chain: a stage loads when empty or when the next one moves
	assign adv[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end
	assign vin       = {vld_q[NS-2:0], in_valid};
	assign ld        = adv[NS-1:0] & vin;
	assign in_ready  = adv[0];
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (adv[k]) vld_q[k] <= vin[k];
			end
		end
	end

	// Constant table of exp samples, Q1.16
	logic [16:0] tab [TLEN];
	for (genvar g = 0; g < TLEN; g++) begin : g_tab
		assign tab[g] = gfpd_pkg::exp_entry(EXP_TABLE_BITS, g);
	end

	logic [EXP_TABLE_BITS:0] idx;
	assign idx = {1'b0, in_x[19:FB]};

	gfpd_pkg::point_t pt_s1, pt_s2, pt_s3;
	logic [16:0]      a_s1, b_s1, a_s2, wi_s3;
	logic [FB-1:0]    f_s1;
	logic             zero_s1, zero_s2;
	logic [PW-1:0]    prod_s2;
	logic [PW:0]      step;

	// Fetch the two neighbouring samples
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			pt_s1   <= in_pt;
			zero_s1 <= in_zero;
			a_s1    <= tab[idx];
			b_s1    <= tab[idx + (EXP_TABLE_BITS + 1)'(1)];
			f_s1    <= in_x[FB-1:0];
		end
	end

	// Scale the sample difference by the fraction
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			pt_s2   <= pt_s1;
			zero_s2 <= zero_s1;
			a_s2    <= a_s1;
			prod_s2 <= PW'(a_s1 - b_s1) * PW'(f_s1);
		end
	end

	assign step = ((PW + 1)'(prod_s2) + ((PW + 1)'(1) << (FB - 1))) >> FB;

	// Interpolated weight, forced to zero out of range
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			pt_s3 <= pt_s2;
			wi_s3 <= zero_s2 ? 17'd0 : (a_s2 - step[16:0]);
		end
	end

	assign out_pt = pt_s3;
	assign out_wi = wi_s3;

endmodule
`default_nettype wire

@@ rtl/gfpd_move.sv @@
// Displacement along the normal scaled by push and weight, with saturating add.
`default_nettype none
module gfpd_move (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire gfpd_pkg::cfg_t   cfg,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire gfpd_pkg::point_t in_pt,
	input  wire logic [16:0]      in_wi,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output gfpd_pkg::point_t      out_pt,
	output logic [15:0]           out_weight
);

	localparam int NS = 4;

	logic [NS-1:0] vld_q;
	logic [NS-1:0] vin;
	logic [NS:0]   adv;
	logic [NS-1:0] ld;

	// Stall chain: a stage loads when empty or when the next one moves
	assign adv[NS] = out_ready;
	for (genvar k = 0; k < NS; k++) begin : g_adv
		assign adv[k] = !vld_q[k] || adv[k+1];
	end
	assign vin       = {vld_q[NS-2:0], in_valid};
	assign ld        = adv[NS-1:0] & vin;
	assign in_ready  = adv[0];
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NS; k++) begin
				if (adv[k]) vld_q[k] <= vin[k];
			end
		end
	end

	// Round the move from Q.30 to Q.16, add and clamp to 32 bits signed
	function automatic logic signed [31:0] add_sat(logic signed [31:0] p,
			logic signed [49:0] m);
		logic signed [49:0] r;
		logic signed [50:0] s;
		r = (m + 50'sd8192) >>> 14;
		s = 51'(p) + 51'(r);
		if (s > 51'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (s < -51'sd2147483648) begin
			return 32'sh80000000;
		end
		return s[31:0];
	endfunction

	gfpd_pkg::point_t   pt_s1, pt_s2, pt_s3, pt_s4;
	logic [15:0]        w_s1, w_s2, w_s3, w_s4;
	logic signed [49:0] qp_s1;
	logic signed [33:0] q_s2;
	logic signed [49:0] mx_s3, my_s3, mz_s3;

	// Push times weight, cap the reported weight
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			pt_s1 <= in_pt;
			w_s1  <= in_wi[16] ? 16'hffff : in_wi[15:0];
			qp_s1 <= 50'($signed(cfg.push_amount)) * 50'($signed({1'b0, in_wi}));
		end
	end

	// Round to Q18.16
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			pt_s2 <= pt_s1;
			w_s2  <= w_s1;
			q_s2  <= 34'((qp_s1 + 50'sd32768) >>> 16);
		end
	end

	// Scale by each normal component
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			pt_s3 <= pt_s2;
			w_s3  <= w_s2;
			mx_s3 <= 50'($signed(cfg.normal_x)) * 50'(q_s2);
			my_s3 <= 50'($signed(cfg.normal_y)) * 50'(q_s2);
			mz_s3 <= 50'($signed(cfg.normal_z)) * 50'(q_s2);
		end
	end

	// Move the vertex
	always_ff @(posedge clk) begin
		if (ld[3]) begin
			w_s4    <= w_s3;
			pt_s4.x <= add_sat(pt_s3.x, mx_s3);
			pt_s4.y <= add_sat(pt_s3.y, my_s3);
			pt_s4.z <= add_sat(pt_s3.z, mz_s3);
		end
	end

	assign out_pt     = pt_s4;
	assign out_weight = w_s4;

endmodule
`default_nettype wire

@@ rtl/gaussian_falloff_point_displacement_top.sv @@
// Datapath: distance, then divide, then exp, then move, from input item to result.
// Throughput: one vertex per cycle unless out_ready stalls; every stage is pipelined,
// the divider resolves one quotient bit per stage and the exp table gives two samples
// per item. Stalls hold each stage; empty stages still fill while the output waits.
// Reset clears all valid bits and loads the registers with their reset values.
`default_nettype none
module gaussian_falloff_point_displacement_top #(
	parameter int EXP_TABLE_BITS = gfpd_pkg::EXP_TABLE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [31:0] point_z,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [31:0]      moved_x,
	output logic signed [31:0]      moved_y,
	output logic signed [31:0]      moved_z,
	output logic [15:0]             weight
);

	gfpd_pkg::cfg_t cfg_q;
	logic [32:0]    den_q;

	assign cfg_ready = 1'b1;

	// Register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{
				normal_x:    '0,
				normal_y:    '0,
				normal_z:    gfpd_pkg::NORMAL_Z_RST,
				pick_x:      '0,
				pick_y:      '0,
				pick_z:      '0,
				push_amount: '0,
				sigma:       gfpd_pkg::SIGMA_RST
			};
		end else if (cfg_valid) begin
			unique case (gfpd_pkg::reg_idx_t'(cfg_index))
				gfpd_pkg::REG_NORMAL_X: cfg_q.normal_x    <= cfg_data[15:0];
				gfpd_pkg::REG_NORMAL_Y: cfg_q.normal_y    <= cfg_data[15:0];
				gfpd_pkg::REG_NORMAL_Z: cfg_q.normal_z    <= cfg_data[15:0];
				gfpd_pkg::REG_PICK_X:   cfg_q.pick_x      <= cfg_data;
				gfpd_pkg::REG_PICK_Y:   cfg_q.pick_y      <= cfg_data;
				gfpd_pkg::REG_PICK_Z:   cfg_q.pick_z      <= cfg_data;
				gfpd_pkg::REG_PUSH:     cfg_q.push_amount <= cfg_data;
				gfpd_pkg::REG_SIGMA:    cfg_q.sigma       <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Divisor 2 sigma^2, Q.16
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q <= 33'({32'(gfpd_pkg::SIGMA_RST) * 32'(gfpd_pkg::SIGMA_RST), 1'b0});
		end else begin
			den_q <= {32'(cfg_q.sigma) * 32'(cfg_q.sigma), 1'b0};
		end
	end

	gfpd_pkg::point_t in_pt, c_pt, d_pt, e_pt, m_pt;
	logic             c_valid, c_ready, c_far;
	logic [57:0]      c_d2;
	logic             d_valid, d_ready, d_zero;
	logic [19:0]      d_x;
	logic             e_valid, e_ready;
	logic [16:0]      e_wi;

	assign in_pt.x = point_x;
	assign in_pt.y = point_y;
	assign in_pt.z = point_z;

	gfpd_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_pt     (in_pt),
		.out_valid (c_valid),
		.out_ready (c_ready),
		.out_pt    (c_pt),
		.out_d2    (c_d2),
		.out_far   (c_far)
	);

	gfpd_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.den       (den_q),
		.in_valid  (c_valid),
		.in_ready  (c_ready),
		.in_pt     (c_pt),
		.in_d2     (c_d2),
		.in_far    (c_far),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_pt    (d_pt),
		.out_x     (d_x),
		.out_zero  (d_zero)
	);

	gfpd_exp #(
		.EXP_TABLE_BITS (EXP_TABLE_BITS)
	) u_exp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.in_pt     (d_pt),
		.in_x      (d_x),
		.in_zero   (d_zero),
		.out_valid (e_valid),
		.out_ready (e_ready),
		.out_pt    (e_pt),
		.out_wi    (e_wi)
	);

	gfpd_move u_move (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (e_valid),
		.in_ready   (e_ready),
		.in_pt      (e_pt),
		.in_wi      (e_wi),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_pt     (m_pt),
		.out_weight (weight)
	);

	assign moved_x = m_pt.x;
	assign moved_y = m_pt.y;
	assign moved_z = m_pt.z;

endmodule
`default_nettype wire
